[design/name_slot_registry_defines.svh]
// ---------------------------------------------------------------------------
// name_slot_registry_defines
// assertion macros used by the name slot registry checker
// ---------------------------------------------------------------------------
`ifndef NAME_SLOT_REGISTRY_DEFINES_SVH
`define NAME_SLOT_REGISTRY_DEFINES_SVH

// condition holds in the same cycle
`define NSR_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("name slot registry check failed");

// condition holds in the following cycle
`define NSR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("name slot registry check failed");

`endif

[design/nsr_pkg.sv]
// ---------------------------------------------------------------------------
// nsr_pkg
// shared constants, codes and control types of the name slot registry
// ---------------------------------------------------------------------------
package nsr_pkg;

  localparam int ENTRIES_DEF  = 1024;
  localparam int STORED_CHARS = 11;
  localparam int INPUT_CHARS  = 16;

  localparam int SLOT_W = 11;
  localparam int NAME_W = 64;
  localparam int TAIL_W = 24;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic norm;
    logic clr;
    logic scan;
    logic rd_req;
    logic rd_zero;
    logic rd_resp;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic is_read;
    logic needs_scan;
    logic rd_redirect;
  } sts_t;

endpackage

[design/name_slot_registry.sv]
// ---------------------------------------------------------------------------
// name_slot_registry
// slot table of short names with add, lookup, read and remove requests
// ---------------------------------------------------------------------------
//  channel  | handshake           | fields
//  ---------+---------------------+------------------------------------------
//  request  | start high, busy low| in_command, in_slot, in_use_first_free,
//           |                     | in_name_first8, in_name_last8
//  result   | out_valid, 1 cycle  | out_status, out_slot_out,
//           |                     | out_name_head_out, out_name_tail_out
//
//  add to a given slot and remove pass through the normalize and finish
//  states; read passes through normalize and RD1, and RD2 as well when
//  the slot is empty (slot 0 is read back); lookup and add with free-slot
//  search also scan the slots below the high mark, one slot per cycle on
//  the store's single read port; after reset a clearing pass writes all
//  ENTRIES slots and busy stays high until it ends; results cannot be
//  stalled, a new request is taken in the same cycle a result is shown
// ---------------------------------------------------------------------------
module name_slot_registry #(
  parameter int ENTRIES = nsr_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [nsr_pkg::CMD_W-1:0]   in_command,
  input  logic [nsr_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        in_use_first_free,
  input  logic [nsr_pkg::NAME_W-1:0]  in_name_first8,
  input  logic [nsr_pkg::NAME_W-1:0]  in_name_last8,
  output logic                        out_valid,
  output logic [nsr_pkg::STAT_W-1:0]  out_status,
  output logic [nsr_pkg::SLOT_W-1:0]  out_slot_out,
  output logic [nsr_pkg::NAME_W-1:0]  out_name_head_out,
  output logic [nsr_pkg::TAIL_W-1:0]  out_name_tail_out
);
  import nsr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  nsr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  nsr_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_command        (in_command),
    .in_slot           (in_slot),
    .in_use_first_free (in_use_first_free),
    .in_name_first8    (in_name_first8),
    .in_name_last8     (in_name_last8),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_name_head_out (out_name_head_out),
    .out_name_tail_out (out_name_tail_out)
  );

endmodule

[design/nsr_ram.sv]
// ---------------------------------------------------------------------------
// nsr_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module nsr_ram #(
  parameter int WIDTH  = 88,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/nsr_ctrl.sv]
// ---------------------------------------------------------------------------
// nsr_ctrl
// sequencer of the name slot registry: clear pass, normalize, scan, respond
// ---------------------------------------------------------------------------
module nsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  nsr_pkg::sts_t sts,
  output nsr_pkg::ctl_t ctl,
  output logic          busy
);
  import nsr_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_NORM   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_RD1    = 7'b0010000,
    S_RD2    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        ctl.norm   = 1'b1;
        ctl.rd_req = sts.is_read;
        if (sts.is_read) begin
          state_nxt = S_RD1;
        end else if (sts.needs_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_RD1: begin
        // empty slot reads back slot 0 instead
        if (sts.rd_redirect) begin
          ctl.rd_zero = 1'b1;
          state_nxt   = S_RD2;
        end else begin
          ctl.rd_resp = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RD2: begin
        ctl.rd_resp = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[design/nsr_dpath.sv]
// ---------------------------------------------------------------------------
// nsr_dpath
// name normalizer, slot store, scan pointer and response registers
// ---------------------------------------------------------------------------
module nsr_dpath #(
  parameter int ENTRIES = nsr_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nsr_pkg::ctl_t               ctl,
  output nsr_pkg::sts_t               sts,
  input  logic [nsr_pkg::CMD_W-1:0]   in_command,
  input  logic [nsr_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        in_use_first_free,
  input  logic [nsr_pkg::NAME_W-1:0]  in_name_first8,
  input  logic [nsr_pkg::NAME_W-1:0]  in_name_last8,
  output logic                        out_valid,
  output logic [nsr_pkg::STAT_W-1:0]  out_status,
  output logic [nsr_pkg::SLOT_W-1:0]  out_slot_out,
  output logic [nsr_pkg::NAME_W-1:0]  out_name_head_out,
  output logic [nsr_pkg::TAIL_W-1:0]  out_name_tail_out
);
  import nsr_pkg::*;

  localparam int AW     = $clog2(ENTRIES);
  localparam int HW     = $clog2(ENTRIES + 1);
  localparam int TW     = (HW > SLOT_W) ? HW : SLOT_W;
  localparam int DATA_W = NAME_W + TAIL_W;

  typedef struct packed {
    logic [NAME_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic              zero;
  } norm_t;

  function automatic norm_t norm_name(input logic [2*NAME_W-1:0] raw);
    logic [7:0]  b [16];
    logic [15:0] sfx;
    logic        run;
    logic [4:0]  len;
    norm_t       res;
    for (int i = 0; i < 16; i++) begin
      b[i] = (i < INPUT_CHARS) ? raw[2*NAME_W-1-8*i -: 8] : 8'h00;
    end
    run = 1'b1;
    len = '0;
    for (int i = 0; i < INPUT_CHARS; i++) begin
      if (run && (b[i] != 8'h00)) begin
        len = len + 5'd1;
      end else begin
        run = 1'b0;
      end
    end
    if (len == 5'(INPUT_CHARS)) begin
      len = len - 5'd1;
    end
    // suffix match for every possible length, then pick by length
    sfx = '0;
    for (int l = 4; l < 16; l++) begin
      sfx[l] = (l < INPUT_CHARS) && (b[l-4] == CH_DOT) &&
               ((b[l-3] | CASE_BIT) == CH_G) &&
               ((b[l-2] | CASE_BIT) == CH_A) &&
               ((b[l-1] | CASE_BIT) == CH_T);
    end
    if ((len >= 5'd4) && sfx[len[3:0]]) begin
      len = len - 5'd4;
    end
    if (len > 5'(STORED_CHARS)) begin
      len = 5'(STORED_CHARS);
    end
    for (int i = 0; i < 8; i++) begin
      res.head[NAME_W-1-8*i -: 8] = (5'(i) < len) ? b[i] : 8'h00;
    end
    for (int i = 0; i < 3; i++) begin
      res.tail[TAIL_W-1-8*i -: 8] = (5'(i + 8) < len) ? b[i+8] : 8'h00;
    end
    res.zero = (len == 5'd0);
    return res;
  endfunction

  // request registers
  cmd_t                  cmd_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  ff_r;
  logic [2*NAME_W-1:0]   raw_r;
  norm_t                 nm_r;

  // control state
  logic [HW-1:0]         hm_r, hm_nxt;
  logic [AW-1:0]         clr_ptr_r, clr_ptr_nxt;
  logic [HW-1:0]         scan_ptr_r, scan_ptr_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]         chk_idx_r, chk_idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [AW-1:0]         hit_idx_r, hit_idx_nxt;
  logic                  redir_r, redir_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // response payload
  logic [STAT_W-1:0]     st_r, st_nxt;
  logic [SLOT_W-1:0]     so_r, so_nxt;
  logic [NAME_W-1:0]     oh_r, oh_nxt;
  logic [TAIL_W-1:0]     ot_r, ot_nxt;

  // store ports
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_W-1:0]     wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DATA_W-1:0]     rd_data;
  logic [NAME_W-1:0]     rd_head;
  logic [TAIL_W-1:0]     rd_tail;

  logic                  rd_empty;
  logic                  crit;
  logic                  match_now;
  logic                  more;
  logic                  slot_ok;
  logic [TW-1:0]         fallback;
  logic [TW-1:0]         tgt;
  logic                  tgt_ok;

  nsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_head  = rd_data[DATA_W-1 -: NAME_W];
  assign rd_tail  = rd_data[TAIL_W-1:0];
  assign rd_empty = (rd_head[NAME_W-1 -: 8] == 8'h00);

  // lookup wants an exact match, free-slot search wants an empty slot
  assign crit      = (cmd_r == CMD_FIND) ? ((rd_head == nm_r.head) && (rd_tail == nm_r.tail))
                                         : rd_empty;
  assign match_now = chk_vld_r && crit;
  assign more      = (scan_ptr_r < hm_r);
  assign slot_ok   = (TW'(slot_r) < TW'(ENTRIES));
  assign fallback  = (hm_r > HW'(1)) ? TW'(hm_r) : TW'(1);
  assign tgt       = !ff_r ? TW'(slot_r) : (hit_r ? TW'(hit_idx_r) : fallback);
  assign tgt_ok    = (tgt < TW'(ENTRIES));

  always_comb begin
    sts.clr_last    = (clr_ptr_r == AW'(ENTRIES - 1));
    sts.scan_done   = match_now || (!chk_vld_r && !more);
    sts.is_read     = (cmd_r == CMD_READ);
    sts.needs_scan  = (cmd_r == CMD_FIND) || ((cmd_r == CMD_ADD) && ff_r);
    sts.rd_redirect = slot_ok && rd_empty;
  end

  always_comb begin
    if (ctl.scan) begin
      rd_addr = scan_ptr_r[AW-1:0];
    end else if (ctl.rd_req && slot_ok) begin
      rd_addr = slot_r[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    hm_nxt        = hm_r;
    clr_ptr_nxt   = clr_ptr_r;
    scan_ptr_nxt  = scan_ptr_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    redir_nxt     = redir_r;
    out_valid_nxt = 1'b0;
    st_nxt        = st_r;
    so_nxt        = so_r;
    oh_nxt        = oh_r;
    ot_nxt        = ot_r;
    wr_en         = 1'b0;
    wr_addr       = clr_ptr_r;
    wr_data       = '0;

    if (ctl.clr) begin
      wr_en       = 1'b1;
      clr_ptr_nxt = clr_ptr_r + AW'(1);
    end

    if (ctl.norm) begin
      scan_ptr_nxt = HW'(1);
      chk_vld_nxt  = 1'b0;
      hit_nxt      = 1'b0;
      redir_nxt    = 1'b0;
    end

    if (ctl.scan) begin
      if (match_now) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = chk_idx_r;
        chk_vld_nxt = 1'b0;
      end else begin
        // one slot read issued per cycle, compared in the cycle after
        chk_vld_nxt = more;
        chk_idx_nxt = scan_ptr_r[AW-1:0];
        if (more) begin
          scan_ptr_nxt = scan_ptr_r + HW'(1);
        end
      end
    end

    if (ctl.rd_zero) begin
      redir_nxt = 1'b1;
    end

    if (ctl.rd_resp) begin
      out_valid_nxt = 1'b1;
      so_nxt        = '0;
      oh_nxt        = rd_head;
      ot_nxt        = rd_tail;
      if (!slot_ok) begin
        st_nxt = ST_RANGE;
      end else if (redir_r || rd_empty) begin
        st_nxt = ST_NOTFOUND;
      end else begin
        st_nxt = ST_OK;
      end
    end

    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
      so_nxt        = '0;
      oh_nxt        = '0;
      ot_nxt        = '0;
      st_nxt        = ST_OK;
      case (cmd_r)
        CMD_ADD: begin
          if (!tgt_ok) begin
            st_nxt = ST_RANGE;
          end else if (nm_r.zero) begin
            st_nxt = ST_EMPTY;
          end else begin
            wr_en   = 1'b1;
            wr_addr = tgt[AW-1:0];
            wr_data = {nm_r.head, nm_r.tail};
            so_nxt  = tgt[SLOT_W-1:0];
            if (TW'(hm_r) <= tgt) begin
              hm_nxt = HW'(tgt + TW'(1));
            end
          end
        end
        CMD_FIND: begin
          if (hit_r) begin
            so_nxt = SLOT_W'(hit_idx_r);
          end else begin
            st_nxt = ST_NOTFOUND;
          end
        end
        CMD_REMOVE: begin
          if (slot_ok) begin
            wr_en   = 1'b1;
            wr_addr = slot_r[AW-1:0];
          end else begin
            st_nxt = ST_RANGE;
          end
        end
        default: begin
          st_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hm_r        <= '0;
      clr_ptr_r   <= '0;
      scan_ptr_r  <= '0;
      chk_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      redir_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hm_r        <= hm_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      hit_r       <= hit_nxt;
      redir_r     <= redir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd_t'(in_command);
      slot_r <= in_slot;
      ff_r   <= in_use_first_free;
      raw_r  <= {in_name_first8, in_name_last8};
    end
    if (ctl.norm) begin
      nm_r <= norm_name(raw_r);
    end
    chk_idx_r <= chk_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    st_r      <= st_nxt;
    so_r      <= so_nxt;
    oh_r      <= oh_nxt;
    ot_r      <= ot_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = st_r;
  assign out_slot_out      = so_r;
  assign out_name_head_out = oh_r;
  assign out_name_tail_out = ot_r;

endmodule

[design/nsr_checker.sv]
// ---------------------------------------------------------------------------
// nsr_checker
// port-level checks of the name slot registry, bound to the top level
// ---------------------------------------------------------------------------
`include "name_slot_registry_defines.svh"

module nsr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [nsr_pkg::STAT_W-1:0]  out_status,
  input logic [nsr_pkg::SLOT_W-1:0]  out_slot_out
);
  import nsr_pkg::*;

  logic rejected;

  assign rejected = out_valid && (out_status == ST_RANGE || out_status == ST_EMPTY);

  // an accepted request makes the block busy in the next cycle
  `NSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // results only leave when the sequencer is back to idle
  `NSR_ASSERT_SAME(a_result_idle, out_valid, !busy)

  // no two results back to back
  `NSR_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

  // rejected requests (out of range or empty name) never report a slot
  `NSR_ASSERT_SAME(a_reject_no_slot, rejected, out_slot_out == '0)

endmodule

bind name_slot_registry nsr_checker u_nsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_slot_out (out_slot_out)
);
